[src/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Clocked property that holds through reset as well
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

[src/fpba_pkg.sv]
// Package of the fit-policy block allocator: sizes, codes, types and helpers.
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Port field widths
    localparam int FLD_IDX_W  = 4;
    localparam int FLD_AMT_W  = 16;
    localparam int TDATA_W    = 24;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } fit_policy_t;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_ALLOC = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } fpba_state_t;

    // Verdict of the shared compare unit on one candidate
    typedef struct packed {
        logic fits;
        logic take;
    } fpba_cmp_t;

    // Sequencer controls
    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic commit;
        logic emit;
    } fpba_ctrl_t;

    // Port amount to block size
    function automatic logic [SIZE_BITS-1:0] amt_from_field(input logic [FLD_AMT_W-1:0] a);
        logic [SIZE_BITS+FLD_AMT_W-1:0] w;
        w = {{SIZE_BITS{1'b0}}, a};
        return w[SIZE_BITS-1:0];
    endfunction

    // Block size to port amount
    function automatic logic [FLD_AMT_W-1:0] amt_to_field(input logic [SIZE_BITS-1:0] a);
        logic [SIZE_BITS+FLD_AMT_W-1:0] w;
        w = {{FLD_AMT_W{1'b0}}, a};
        return w[FLD_AMT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_from_field(input logic [FLD_IDX_W-1:0] i);
        logic [IDX_W+FLD_IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, i};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [FLD_IDX_W-1:0] idx_to_field(input logic [IDX_W-1:0] i);
        logic [IDX_W+FLD_IDX_W-1:0] w;
        w = {{FLD_IDX_W{1'b0}}, i};
        return w[FLD_IDX_W-1:0];
    endfunction

endpackage

[src/fpba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/fpba_cmp.sv]
// Shared compare unit: does a candidate fit, and does it beat the current pick.
module fpba_cmp
    import fpba_pkg::*;
(
    input  logic [SIZE_BITS-1:0] cand,
    input  logic [SIZE_BITS-1:0] best,
    input  logic [SIZE_BITS-1:0] amount,
    input  logic                 found,
    input  logic [1:0]           policy,
    output fpba_cmp_t            verdict
);

    logic better;

    // Strict compares keep ties on the lower index
    always_comb begin
        unique case (policy)
            POL_BEST:  better = cand < best;
            POL_WORST: better = cand > best;
            default:   better = 1'b0;
        endcase
    end

    assign verdict.fits = cand >= amount;
    assign verdict.take = verdict.fits && (!found || better);

endmodule

[src/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: sequencer, block store and result register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: action; tdata: block_index, amount
//  m_       | out | m_tvalid/m_tready  | tuser: granted; tdata: chosen_block, space_left
//  cfg_     | in  | cfg_wr_en          | cfg_wr_data: fit_policy
//
//  A load passes through its transfer and the hand-over; an allocation passes through the
//  transfer, a scan of one block a cycle through the one compare unit over the RAM read port,
//  a drain step for the registered read, a write-back and the hand-over. m_tvalid is
//  registered and rises after the hand-over.
//  s_tready is high only while the sequencer is idle; a held result stalls the next hand-over.
//  aresetn is synchronous and active low; it empties all blocks through per-block valid bits.
`include "assert_macros.svh"

module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // config
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,   // fit_policy
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,       // [3:0] block_index, [19:4] amount, rest zero
    input  logic               s_tuser,       // [0] action
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,       // [3:0] chosen_block, [19:4] space_left, rest 0
    output logic               m_tuser        // [0] granted
);

    fpba_state_t state_reg, state_next;
    fpba_ctrl_t  ctrl;
    fpba_cmp_t   verdict;

    logic [1:0]            policy_reg;
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [SIZE_BITS-1:0]  amt_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_BITS-1:0]  best_val_reg;
    logic                  res_grant_reg;
    logic [IDX_W-1:0]      res_idx_reg;
    logic [SIZE_BITS-1:0]  res_left_reg;
    logic                  m_valid_reg;
    logic [TDATA_W-1:0]    m_data_reg;
    logic                  m_user_reg;

    logic                  s_accept;
    logic                  scan_end;
    logic                  load_ok;
    logic [SIZE_BITS-1:0]  in_amt;
    logic [IDX_W-1:0]      in_idx;
    logic [SIZE_BITS-1:0]  rdata;
    logic [SIZE_BITS-1:0]  cand;
    logic [SIZE_BITS-1:0]  diff;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_BITS-1:0]  ram_wdata;

    assign s_accept = s_tvalid && s_tready;
    assign scan_end = cnt_reg == IDX_W'(NUM_BLOCKS - 1);
    assign in_amt   = amt_from_field(s_tdata[FLD_IDX_W +: FLD_AMT_W]);
    assign in_idx   = idx_from_field(s_tdata[FLD_IDX_W-1:0]);
    assign load_ok  = {28'd0, s_tdata[FLD_IDX_W-1:0]} < 32'(NUM_BLOCKS);
    assign diff     = best_val_reg - amt_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == ACT_ALLOC) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:  ctrl.accept  = 1'b1;
            ST_SCAN:  ctrl.scan_rd = 1'b1;
            ST_DRAIN: ctrl         = '0;
            ST_WRITE: ctrl.commit  = 1'b1;
            ST_DONE:  ctrl.emit    = !m_valid_reg || m_tready;
            default:  ctrl         = '0;
        endcase
    end

    assign s_tready = ctrl.accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Policy register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIRST;
        end else if (cfg_wr_en) begin
            policy_reg <= cfg_wr_data;
        end
    end

    // RAM write port: load on transfer, or write-back of the pick
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = in_idx;
        ram_wdata = in_amt;
        if (ctrl.commit) begin
            ram_we    = found_reg;
            ram_waddr = best_idx_reg;
            ram_wdata = diff;
        end else if (s_accept && s_tuser == ACT_LOAD) begin
            ram_we    = load_ok;
        end
    end

    fpba_ram #(
        .WIDTH(SIZE_BITS),
        .DEPTH(NUM_BLOCKS)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(cnt_reg),
        .rdata(rdata)
    );

    // Per-block valid bits; an unwritten block reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[ram_waddr] <= 1'b1;
        end
    end

    assign cand = valid_reg[rd_idx_reg] ? rdata : '0;

    fpba_cmp u_cmp (
        .cand   (cand),
        .best   (best_val_reg),
        .amount (amt_reg),
        .found  (found_reg),
        .policy (policy_reg),
        .verdict(verdict)
    );

    // Scan counter and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= ctrl.scan_rd;
            if (ctrl.scan_rd) begin
                cnt_reg <= scan_end ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
    end

    // Running pick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (s_accept) begin
            found_reg <= 1'b0;
        end else if (rd_vld_reg && verdict.take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            amt_reg <= in_amt;
        end
        if (rd_vld_reg && verdict.take) begin
            best_idx_reg <= rd_idx_reg;
            best_val_reg <= cand;
        end
    end

    // Result staging
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_grant_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_left_reg  <= '0;
        end else if (ctrl.commit) begin
            res_grant_reg <= found_reg;
            res_idx_reg   <= found_reg ? best_idx_reg : '0;
            res_left_reg  <= found_reg ? diff : '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_user_reg <= res_grant_reg;
            m_data_reg <= {{(TDATA_W - FLD_IDX_W - FLD_AMT_W){1'b0}},
                           amt_to_field(res_left_reg), idx_to_field(res_idx_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    `ASSERT_CLK(a_scan_flow, aclk, aresetn,
        state_reg == ST_SCAN |=> state_reg == ST_SCAN || state_reg == ST_DRAIN)
    `ASSERT_CLK(a_pick_fits, aclk, aresetn,
        (ctrl.commit && found_reg) |-> best_val_reg >= amt_reg)
    `ASSERT_CLK(a_no_accept_mid_scan, aclk, aresetn,
        s_accept |-> !rd_vld_reg && !ctrl.commit)
    `ASSERT_CLK(a_refusal_zero, aclk, aresetn,
        (m_tvalid && !m_tuser) |-> m_tdata == '0)

endmodule
